// ===== sv/kcrp_pkg.sv =====
// Shared types, codes and constants for the keyed configuration register port.
// Used by the front end, the queue, the back end and the top level.
// No dependencies.
package kcrp_pkg;

   // Command codes on the request stream.
   typedef enum logic [1:0] {
      CMD_INDEX_WR = 2'd0,
      CMD_DATA_RD  = 2'd1,
      CMD_DATA_WR  = 2'd2,
      CMD_UNUSED   = 2'd3
   } cmd_type;

   // Work handed from the front end to the back end.
   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2,
      OP_SPARE = 2'd3
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  index;
      logic [7:0]  wdata;
      logic        seq_error;
      logic        unlocked;
   } op_type;

   // Segment shadow modes.
   typedef enum logic [1:0] {
      SEG_ROM      = 2'd0,
      SEG_SHADOW_W = 2'd1,
      SEG_SHADOW_RW= 2'd2,
      SEG_SPARE    = 2'd3
   } seg_mode_type;

   localparam logic [7:0] KEY_FIRST   = 8'hA0;
   localparam logic [7:0] KEY_SECOND  = 8'h05;
   localparam logic [7:0] KEY_LOCK    = 8'hA5;
   localparam logic [7:0] REG_SEG_E   = 8'h35;
   localparam logic [7:0] REG_SEG_F   = 8'h36;

   localparam int REG_DEPTH     = 256;
   localparam int QUEUE_DEPTH   = 2;

   // Bit 6 gives shadow read-write, otherwise bit 4 gives shadow write-only.
   function automatic seg_mode_type seg_mode(input logic [7:0] value);
      seg_mode_type mode;
      if (value[6]) begin
         mode = SEG_SHADOW_RW;
      end else if (value[4]) begin
         mode = SEG_SHADOW_W;
      end else begin
         mode = SEG_ROM;
      end
      return mode;
   endfunction

endpackage

// ===== sv/kcrp_front.sv =====
// Front end: accepts requests, tracks the unlock sequence and the selected index,
// and turns each request into an operation for the back end. Uses kcrp_pkg.
module kcrp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  kcrp_pkg::cmd_type   cmd,
   input  logic [7:0]          wdata,
   output logic                push_valid,
   input  logic                push_ready,
   output kcrp_pkg::op_type    push_op
);

   typedef enum logic [1:0] {
      PH_KEY1 = 2'd0,
      PH_KEY2 = 2'd1,
      PH_ADDR = 2'd2,
      PH_DATA = 2'd3
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] index_ff, index_in;
   logic       accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   // Classify the request against the current phase.
   always_comb begin
      phase_in            = phase_ff;
      index_in            = index_ff;
      push_op.kind        = kcrp_pkg::OP_NONE;
      push_op.index       = index_ff;
      push_op.wdata       = wdata;
      push_op.seq_error   = 1'b0;
      unique case (cmd) inside
         kcrp_pkg::CMD_INDEX_WR: begin
            unique case (phase_ff)
               PH_KEY1: begin
                  if (wdata == kcrp_pkg::KEY_FIRST) phase_in = PH_KEY2;
                  else push_op.seq_error = 1'b1;
               end
               PH_KEY2: begin
                  if (wdata == kcrp_pkg::KEY_SECOND) phase_in = PH_ADDR;
                  else push_op.seq_error = 1'b1;
               end
               PH_ADDR: begin
                  if (wdata == kcrp_pkg::KEY_LOCK) begin
                     phase_in = PH_KEY1;
                  end else begin
                     index_in = wdata;
                     phase_in = PH_DATA;
                  end
               end
               default: push_op.seq_error = 1'b1;
            endcase
         end
         kcrp_pkg::CMD_DATA_RD, kcrp_pkg::CMD_DATA_WR: begin
            if (phase_ff == PH_DATA) begin
               phase_in     = PH_ADDR;
               push_op.kind = (cmd == kcrp_pkg::CMD_DATA_RD) ? kcrp_pkg::OP_READ
                                                             : kcrp_pkg::OP_WRITE;
            end else begin
               push_op.seq_error = 1'b1;
            end
         end
         default: ;
      endcase
      push_op.unlocked = (phase_in == PH_ADDR) || (phase_in == PH_DATA);
   end

   // Phase and index registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_KEY1;
         index_ff <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         index_ff <= index_in;
      end
   end

endmodule

// ===== sv/kcrp_queue.sv =====
// Short first-in first-out queue of operations between the front and back ends.
// Uses kcrp_pkg for the operation type.
module kcrp_queue #(
   parameter int DEPTH = kcrp_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  kcrp_pkg::op_type push_op,
   output logic             pop_valid,
   input  logic             pop_ready,
   output kcrp_pkg::op_type pop_op
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   kcrp_pkg::op_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_op     = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         if (push && !pop)      count_ff <= count_ff + CNT_W'(1);
         else if (pop && !push) count_ff <= count_ff - CNT_W'(1);
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_op;
   end

endmodule

// ===== sv/kcrp_back.sv =====
// Back end: carries out register file reads and writes, keeps the segment
// shadow registers and holds the response register. Uses kcrp_pkg.
module kcrp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  kcrp_pkg::op_type      pop_op,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_rdata,
   output logic                  rsp_seq_error,
   output logic                  rsp_unlocked,
   output kcrp_pkg::seg_mode_type rsp_seg_e,
   output kcrp_pkg::seg_mode_type rsp_seg_f
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_ACCESS = 2'd1,
      ST_HOLD   = 2'd2
   } state_type;

   state_type        state_ff;
   kcrp_pkg::op_type op_ff;
   logic [7:0]       mem [kcrp_pkg::REG_DEPTH];
   logic [kcrp_pkg::REG_DEPTH-1:0] valid_ff;
   logic [7:0]       rd_data_ff;
   logic             rd_valid_ff;
   logic [7:0]       seg_e_reg_ff, seg_f_reg_ff;
   logic             rsp_valid_ff;
   logic [7:0]       rsp_rdata_ff;
   logic             rsp_seq_error_ff, rsp_unlocked_ff;
   kcrp_pkg::seg_mode_type rsp_seg_e_ff, rsp_seg_f_ff;
   logic             take, wr_en;

   assign pop_ready     = (state_ff == ST_IDLE);
   assign take          = pop_valid && pop_ready;
   assign wr_en         = take && (pop_op.kind == kcrp_pkg::OP_WRITE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rdata     = rsp_rdata_ff;
   assign rsp_seq_error = rsp_seq_error_ff;
   assign rsp_unlocked  = rsp_unlocked_ff;
   assign rsp_seg_e     = rsp_seg_e_ff;
   assign rsp_seg_f     = rsp_seg_f_ff;

   // Register file: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) mem[pop_op.index] <= pop_op.wdata;
      if (take)  rd_data_ff <= mem[pop_op.index];
   end

   // Sequencer, valid bits, shadow registers and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         seg_e_reg_ff <= 8'd0;
         seg_f_reg_ff <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (take) begin
                  op_ff       <= pop_op;
                  rd_valid_ff <= valid_ff[pop_op.index];
                  if (wr_en) begin
                     valid_ff[pop_op.index] <= 1'b1;
                     if (pop_op.index == kcrp_pkg::REG_SEG_E) seg_e_reg_ff <= pop_op.wdata;
                     if (pop_op.index == kcrp_pkg::REG_SEG_F) seg_f_reg_ff <= pop_op.wdata;
                  end
                  state_ff <= ST_ACCESS;
               end
            end
            ST_ACCESS: begin
               // An entry never written since reset reads as zero.
               rsp_rdata_ff     <= (op_ff.kind == kcrp_pkg::OP_READ && rd_valid_ff)
                                   ? rd_data_ff : 8'd0;
               rsp_seq_error_ff <= op_ff.seq_error;
               rsp_unlocked_ff  <= op_ff.unlocked;
               rsp_seg_e_ff     <= kcrp_pkg::seg_mode(seg_e_reg_ff);
               rsp_seg_f_ff     <= kcrp_pkg::seg_mode(seg_f_reg_ff);
               rsp_valid_ff     <= 1'b1;
               state_ff         <= ST_HOLD;
            end
            ST_HOLD: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== sv/keyed_config_register_port.sv =====
// Top level of the keyed configuration register port.
// Instantiates kcrp_front, kcrp_queue and kcrp_back; uses kcrp_pkg.
//
//  Channel | Direction | tdata (low bit up)                         | tuser
//  req     | in        | wdata[7:0]                                 | cmd[1:0]
//  rsp     | out       | rdata[7:0], unlocked, seg_e[1:0], seg_f[1:0] | seq_error
//
// The front end takes one request per cycle while the queue has room.
// The back end works through each request in turn: queue pop with register
// file read, response load, and the response handoff; it takes no new request
// until the last one is handed off, so it sets the sustained rate.
// Reset is synchronous; the register file valid bits clear at once, no sweep.
// A stalled response holds the back end; the queue then fills and stalls req.
module keyed_config_register_port #(
   parameter int QUEUE_DEPTH = kcrp_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] wdata
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] rdata, [8] unlocked, [10:9] seg_e_mode,
                                    // [12:11] seg_f_mode, [15:13] zero
   output logic        rsp_tuser    // [0] seq_error
);

   kcrp_pkg::op_type       push_op, pop_op;
   logic                   push_valid, push_ready, pop_valid, pop_ready;
   logic [7:0]             rdata;
   logic                   unlocked;
   kcrp_pkg::seg_mode_type seg_e, seg_f;

   kcrp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .cmd        (kcrp_pkg::cmd_type'(req_tuser)),
      .wdata      (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op)
   );

   kcrp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op)
   );

   kcrp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_op        (pop_op),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_rdata     (rdata),
      .rsp_seq_error (rsp_tuser),
      .rsp_unlocked  (unlocked),
      .rsp_seg_e     (seg_e),
      .rsp_seg_f     (seg_f)
   );

   // Pack the response fields.
   assign rsp_tdata = {3'b000, seg_f, seg_e, unlocked, rdata};

endmodule

// ===== sv/kcrp_checker.sv =====
// Port-level checker for the keyed configuration register port, with its bind.
// Sees only the top level's ports; no package dependency.
module kcrp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A response is withdrawn only once taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // The response cannot appear in the cycle after a reset cycle.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid straight after reset");

   // An out-of-sequence request always returns zero data.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[7:0] == 8'd0)
      else $error("error response carries data");

   // Segment modes never use the spare code, and the padding stays zero.
   a_seg_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[10:9] != 2'd3 && rsp_tdata[12:11] != 2'd3
                     && rsp_tdata[15:13] == 3'd0)
      else $error("bad segment mode or padding");

endmodule

bind keyed_config_register_port kcrp_checker u_kcrp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
